FILE: sv/csb_pkg.sv
// Shared types and constants for the cross stencil blur.
// No dependencies; csb_ctrl, csb_out and the top use scoped names, the bench imports it.
`default_nettype none

package csb_pkg;

  localparam int DEF_MAX_RADIUS = 8;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int RADIUS_RST = 3;
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  localparam int RADIUS_W   = 4;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;

  typedef struct packed {
    logic [7:0] ch_c;
    logic [7:0] ch_b;
    logic [7:0] ch_a;
  } pix_t;

  typedef struct packed {
    logic interior;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

FILE: sv/csb_if.sv
// Valid/ready stream interfaces for the pixel input and result channels.
// Standalone; no package dependency.
`default_nettype none

interface csb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;

  modport source (output valid, cmd, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, cmd, chan_a, chan_b, chan_c, output ready);
endinterface

interface csb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_a;
  logic [7:0] out_b;
  logic [7:0] out_c;
  logic       frame_end;

  modport source (output valid, out_a, out_b, out_c, frame_end, input ready);
  modport sink   (input valid, out_a, out_b, out_c, frame_end, output ready);
endinterface

`default_nettype wire

FILE: sv/cross_stencil_blur.sv
// Top level of the cross stencil blur: control, three line-store copies, output stage.
// Depends on csb_pkg, csb_if, csb_ram, csb_ctrl and csb_out.
//
// Takes one word per clock, pixel or drain, with no gaps of its own unless a stalled
// output holds the input. A pixel word is written into the line ring in the cycle it is
// accepted; the result word it releases (output lags input by radius*image_width+radius
// pixels) passes the address register, registered line-store read and result register.
// The five stencil taps are read together from three copies of the ring (up/down,
// left/right, center), each 2*MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1 words of 24 bits. Ring
// contents are not cleared after reset; every used tap holds a pixel of the current
// frame. After the last pixel of a frame, drain words (or further pixels, which are
// dropped) flush the remaining results one per word; frame_end marks the last one,
// then the next pixel starts a new frame. A radius, width or height write restarts it.
`default_nettype none

module cross_stencil_blur #(
  parameter int MAX_RADIUS = csb_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = csb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = csb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [csb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [csb_pkg::CFG_DATA_W-1:0] cfg_data,
  csb_in_if.sink                         in_s,
  csb_out_if.source                      out_m
);

  localparam int DEPTH  = 2 * MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PIX_W  = $bits(csb_pkg::pix_t);

  logic              s1_en, s2_en, out_en;
  logic              s1_vld;
  csb_pkg::tag_t     s1_tag;
  logic [ADDR_W-1:0] s1_ctr, s1_up, s1_dn, s1_lf, s1_rt;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  csb_pkg::pix_t     wr_data;
  csb_pkg::pix_t     in_pix;

  logic              s2_vld_r;
  csb_pkg::tag_t     s2_tag_r;

  logic [ADDR_W-1:0] vert_a [2];
  logic [PIX_W-1:0]  vert_d [2];
  logic [ADDR_W-1:0] horz_a [2];
  logic [PIX_W-1:0]  horz_d [2];
  logic [ADDR_W-1:0] ctr_a  [1];
  logic [PIX_W-1:0]  ctr_d  [1];

  assign in_pix = '{ch_c: in_s.chan_c, ch_b: in_s.chan_b, ch_a: in_s.chan_a};

  assign s2_en      = !s2_vld_r || out_en;
  assign s1_en      = !s1_vld || s2_en;
  assign in_s.ready = s1_en;

  csb_ctrl #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_valid (in_s.valid),
    .in_cmd   (in_s.cmd),
    .in_pix   (in_pix),
    .s1_en    (s1_en),
    .s1_vld   (s1_vld),
    .s1_tag   (s1_tag),
    .s1_ctr   (s1_ctr),
    .s1_up    (s1_up),
    .s1_dn    (s1_dn),
    .s1_lf    (s1_lf),
    .s1_rt    (s1_rt),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  assign vert_a[0] = s1_up;
  assign vert_a[1] = s1_dn;
  assign horz_a[0] = s1_lf;
  assign horz_a[1] = s1_rt;
  assign ctr_a[0]  = s1_ctr;

  csb_ram #(.DEPTH(DEPTH), .DATA_W(PIX_W), .N_RD(2)) u_ram_vert (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (s2_en),
    .rd_addr (vert_a),
    .rd_data (vert_d)
  );

  csb_ram #(.DEPTH(DEPTH), .DATA_W(PIX_W), .N_RD(2)) u_ram_horz (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (s2_en),
    .rd_addr (horz_a),
    .rd_data (horz_d)
  );

  csb_ram #(.DEPTH(DEPTH), .DATA_W(PIX_W), .N_RD(1)) u_ram_ctr (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (s2_en),
    .rd_addr (ctr_a),
    .rd_data (ctr_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_en) begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_tag_r <= s1_tag;
    end
  end

  csb_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .s2_vld (s2_vld_r),
    .s2_tag (s2_tag_r),
    .px_up  (csb_pkg::pix_t'(vert_d[0])),
    .px_dn  (csb_pkg::pix_t'(vert_d[1])),
    .px_lf  (csb_pkg::pix_t'(horz_d[0])),
    .px_rt  (csb_pkg::pix_t'(horz_d[1])),
    .px_ctr (csb_pkg::pix_t'(ctr_d[0])),
    .out_en (out_en),
    .out_m  (out_m)
  );

  // a held read address must not see a newer write before its read
  a_no_wr_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld && !s2_en |-> !wr_en)
    else $error("line store written while a read is stalled");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && !s2_en |=> s2_vld_r && $stable(s2_tag_r))
    else $error("read stage word lost or changed while stalled");

  // last pixel of a frame sits on the bottom row, so it always passes through
  a_last_is_edge: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && s2_tag_r.last |-> !s2_tag_r.interior)
    else $error("frame end flagged on an interior pixel");

endmodule

`default_nettype wire

FILE: sv/csb_ram.sv
// Simple line store: one write port, N_RD registered read ports, read-first.
// No package dependency.
`default_nettype none

module csb_ram #(
  parameter  int DEPTH  = 16,
  parameter  int DATA_W = 24,
  parameter  int N_RD   = 1,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr [N_RD],
  output logic [DATA_W-1:0] rd_data [N_RD]
);

  logic [DATA_W-1:0] mem_r     [DEPTH];
  logic [DATA_W-1:0] rd_data_r [N_RD];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      for (int i = 0; i < N_RD; i++) begin
        rd_data_r[i] <= mem_r[rd_addr[i]];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/csb_ctrl.sv
// Config registers, frame counters and ring address generation.
// Depends on csb_pkg; feeds the line stores and the read stage.
`default_nettype none

module csb_ctrl #(
  parameter  int MAX_RADIUS = csb_pkg::DEF_MAX_RADIUS,
  parameter  int MAX_WIDTH  = csb_pkg::DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = csb_pkg::DEF_MAX_HEIGHT,
  localparam int DEPTH      = 2 * MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1,
  localparam int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [csb_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [csb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  input  logic                             in_cmd,
  input  csb_pkg::pix_t                    in_pix,
  input  logic                             s1_en,
  output logic                             s1_vld,
  output csb_pkg::tag_t                    s1_tag,
  output logic [ADDR_W-1:0]                s1_ctr,
  output logic [ADDR_W-1:0]                s1_up,
  output logic [ADDR_W-1:0]                s1_dn,
  output logic [ADDR_W-1:0]                s1_lf,
  output logic [ADDR_W-1:0]                s1_rt,
  output logic                             wr_en,
  output logic [ADDR_W-1:0]                wr_addr,
  output csb_pkg::pix_t                    wr_data
);

  localparam int R_W   = $clog2(MAX_RADIUS + 1);
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int LAG_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam int R_RST = (csb_pkg::RADIUS_RST > MAX_RADIUS) ? MAX_RADIUS : csb_pkg::RADIUS_RST;
  localparam int W_RST = (csb_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : csb_pkg::WIDTH_RST;
  localparam int H_RST = (csb_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : csb_pkg::HEIGHT_RST;

  localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(DEPTH);

  function automatic int unsigned clamp_val(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    else if (v > hi) return hi;
    else return v;
  endfunction

  function automatic logic [ADDR_W-1:0] add_mod(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] sub_mod(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (a < b) s = s + DEPTH_X;
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] inc_mod(input logic [ADDR_W-1:0] a);
    if (32'(a) == DEPTH - 1) return '0;
    else return a + ADDR_W'(1);
  endfunction

  logic [R_W-1:0]   rad_r, rad_nxt;
  logic [W_W-1:0]   wid_r, wid_nxt;
  logic [H_W-1:0]   hgt_r, hgt_nxt;
  logic [LAG_W-1:0] rw_r, rw_nxt;
  logic [LAG_W-1:0] lag_r, lag_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;

  logic [CNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ADDR_W-1:0] wptr_r, wptr_nxt;
  logic [ADDR_W-1:0] rptr_r, rptr_nxt;

  logic              s1_vld_r;
  csb_pkg::tag_t     s1_tag_r;
  logic [ADDR_W-1:0] s1_ctr_r, s1_up_r, s1_dn_r, s1_lf_r, s1_rt_r;

  logic        cfg_hit;
  logic        acc, pix, take, emit, last, interior, col_wrap;
  logic [31:0] guard;
  logic [ADDR_W-1:0] rw_a, r_a;

  // config writes; derived products follow the new values in the same cycle
  always_comb begin
    rad_nxt = rad_r;
    wid_nxt = wid_r;
    hgt_nxt = hgt_r;
    if (cfg_we) begin
      if (cfg_idx == csb_pkg::REG_RADIUS) begin
        rad_nxt = R_W'(clamp_val(32'(cfg_data[csb_pkg::RADIUS_W-1:0]), MAX_RADIUS));
      end else if (cfg_idx == csb_pkg::REG_WIDTH) begin
        wid_nxt = W_W'(clamp_val(32'(cfg_data[csb_pkg::SIZE_W-1:0]), MAX_WIDTH));
      end else if (cfg_idx == csb_pkg::REG_HEIGHT) begin
        hgt_nxt = H_W'(clamp_val(32'(cfg_data[csb_pkg::SIZE_W-1:0]), MAX_HEIGHT));
      end
    end
    rw_nxt    = LAG_W'(rad_nxt) * LAG_W'(wid_nxt);
    lag_nxt   = rw_nxt + LAG_W'(rad_nxt);
    total_nxt = CNT_W'(wid_nxt) * CNT_W'(hgt_nxt);
  end

  assign cfg_hit = cfg_we && (cfg_idx == csb_pkg::REG_RADIUS ||
                              cfg_idx == csb_pkg::REG_WIDTH  ||
                              cfg_idx == csb_pkg::REG_HEIGHT);

  assign acc  = in_valid && s1_en;
  assign pix  = (in_cmd == csb_pkg::CMD_PIXEL);
  assign take = acc && pix && (in_cnt_r < total_r);

  always_comb begin
    if (take) begin
      emit = (32'(in_cnt_r) >= 32'(lag_r));
    end else begin
      emit = acc && (in_cnt_r == total_r) && (out_cnt_r < total_r);
    end
  end

  assign last     = (32'(out_cnt_r) + 32'd1 == 32'(total_r));
  assign guard    = 32'(rad_r) + 32'd1;
  assign interior = (32'(out_row_r) >= guard) && (32'(out_row_r) + guard < 32'(hgt_r)) &&
                    (32'(out_col_r) >= guard) && (32'(out_col_r) + guard < 32'(wid_r));
  assign col_wrap = (32'(out_col_r) + 32'd1 >= 32'(wid_r));

  assign rw_a = ADDR_W'(rw_r);
  assign r_a  = ADDR_W'(rad_r);

  always_comb begin
    in_cnt_nxt  = in_cnt_r;
    wptr_nxt    = wptr_r;
    out_cnt_nxt = out_cnt_r;
    rptr_nxt    = rptr_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (take) begin
      in_cnt_nxt = in_cnt_r + CNT_W'(1);
      wptr_nxt   = inc_mod(wptr_r);
    end
    if (emit) begin
      out_cnt_nxt = out_cnt_r + CNT_W'(1);
      rptr_nxt    = inc_mod(rptr_r);
      if (col_wrap) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end
    if (cfg_hit || (emit && last)) begin
      in_cnt_nxt  = '0;
      wptr_nxt    = '0;
      out_cnt_nxt = '0;
      rptr_nxt    = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r     <= R_W'(R_RST);
      wid_r     <= W_W'(W_RST);
      hgt_r     <= H_W'(H_RST);
      rw_r      <= LAG_W'(R_RST * W_RST);
      lag_r     <= LAG_W'(R_RST * W_RST + R_RST);
      total_r   <= CNT_W'(W_RST * H_RST);
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      wptr_r    <= '0;
      rptr_r    <= '0;
      s1_vld_r  <= 1'b0;
    end else begin
      rad_r     <= rad_nxt;
      wid_r     <= wid_nxt;
      hgt_r     <= hgt_nxt;
      rw_r      <= rw_nxt;
      lag_r     <= lag_nxt;
      total_r   <= total_nxt;
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      wptr_r    <= wptr_nxt;
      rptr_r    <= rptr_nxt;
      if (s1_en) begin
        s1_vld_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_tag_r <= '{interior: interior, last: last};
      s1_ctr_r <= rptr_r;
      s1_up_r  <= sub_mod(rptr_r, rw_a);
      s1_dn_r  <= add_mod(rptr_r, rw_a);
      s1_lf_r  <= sub_mod(rptr_r, r_a);
      s1_rt_r  <= add_mod(rptr_r, r_a);
    end
  end

  assign s1_vld  = s1_vld_r;
  assign s1_tag  = s1_tag_r;
  assign s1_ctr  = s1_ctr_r;
  assign s1_up   = s1_up_r;
  assign s1_dn   = s1_dn_r;
  assign s1_lf   = s1_lf_r;
  assign s1_rt   = s1_rt_r;
  assign wr_en   = take;
  assign wr_addr = wptr_r;
  assign wr_data = in_pix;

endmodule

`default_nettype wire

FILE: sv/csb_out.sv
// Four-point mean or pass-through, and the result word register.
// Depends on csb_pkg and csb_out_if.
`default_nettype none

module csb_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s2_vld,
  input  csb_pkg::tag_t     s2_tag,
  input  csb_pkg::pix_t     px_up,
  input  csb_pkg::pix_t     px_dn,
  input  csb_pkg::pix_t     px_lf,
  input  csb_pkg::pix_t     px_rt,
  input  csb_pkg::pix_t     px_ctr,
  output logic              out_en,
  csb_out_if.source         out_m
);

  function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    logic [9:0] s;
    s = 10'(a) + 10'(b) + 10'(c) + 10'(d);
    return s[9:2];
  endfunction

  logic       vld_r;
  logic [7:0] a_r, b_r, c_r;
  logic       last_r;
  logic [7:0] a_nxt, b_nxt, c_nxt;

  assign out_en = !vld_r || out_m.ready;

  always_comb begin
    if (s2_tag.interior) begin
      a_nxt = avg4(px_up.ch_a, px_dn.ch_a, px_lf.ch_a, px_rt.ch_a);
      b_nxt = avg4(px_up.ch_b, px_dn.ch_b, px_lf.ch_b, px_rt.ch_b);
      c_nxt = avg4(px_up.ch_c, px_dn.ch_c, px_lf.ch_c, px_rt.ch_c);
    end else begin
      a_nxt = px_ctr.ch_a;
      b_nxt = px_ctr.ch_b;
      c_nxt = px_ctr.ch_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_en) begin
      vld_r <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      last_r <= s2_tag.last;
    end
  end

  assign out_m.valid     = vld_r;
  assign out_m.out_a     = a_r;
  assign out_m.out_b     = b_r;
  assign out_m.out_c     = c_r;
  assign out_m.frame_end = last_r;

endmodule

`default_nettype wire

FILE: bench/tb_cross_stencil_blur.sv
// Self-checking bench for cross_stencil_blur: a stimulus table with a few typed results,
// an extreme geometry sweep and random frames; other words are scored against an in-bench stencil model.
// Depends on csb_pkg, csb_if and the cross_stencil_blur RTL.
module tb_cross_stencil_blur;
  import csb_pkg::*;

  localparam logic                 CMD_DRAIN   = ~CMD_PIXEL;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
  localparam int unsigned RING_D       = 2 * DEF_MAX_RADIUS * DEF_MAX_WIDTH + DEF_MAX_RADIUS + 1;
  localparam int unsigned LIMIT        = 200000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned ITEM_BUDGET  = 950;

  typedef enum logic { ROW_REG, ROW_WORD } row_kind_t;

  typedef struct packed {
    pix_t px;
    logic last;
  } blur_word_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  cmd;
    pix_t                  px;
    bit                    known;
    blur_word_t            want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  csb_in_if  in_ch ();
  csb_out_if out_ch ();

  cross_stencil_blur dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_s     (in_ch),
    .out_m    (out_ch)
  );

  // stencil model state
  logic [23:0] ring_px [RING_D];
  int unsigned rad_reg = RADIUS_RST;
  int unsigned wid_reg = WIDTH_RST;
  int unsigned hgt_reg = HEIGHT_RST;
  int unsigned frame_in = 0;
  int unsigned frame_out = 0;
  int unsigned out_row = 0;
  int unsigned out_col = 0;

  blur_word_t  owed_px [$];
  stim_row_t   script [$];
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned items_sent = 0;
  bit          calm = 1'b0;
  bit          hold_now = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic void restart_frame();
    frame_in  = 0;
    frame_out = 0;
    out_row   = 0;
    out_col   = 0;
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_RADIUS: rad_reg = 32'(val[RADIUS_W-1:0]);
      REG_WIDTH:  wid_reg = 32'(val);
      REG_HEIGHT: hgt_reg = 32'(val);
      default:    return;
    endcase
    restart_frame();
  endfunction

  // One accepted word through the stencil; returns 1 when it releases an output pixel.
  function automatic bit cross_mean_step(input logic cmd, input pix_t px,
                                         output blur_word_t res);
    int unsigned r, w, h, total, lag, g, k;
    logic [23:0] up, dn, lf, rt, acc;
    logic [9:0]  sum;
    bit          fire;
    r     = clamp_reg(rad_reg, DEF_MAX_RADIUS);
    w     = clamp_reg(wid_reg, DEF_MAX_WIDTH);
    h     = clamp_reg(hgt_reg, DEF_MAX_HEIGHT);
    total = w * h;
    lag   = r * w + r;
    g     = r + 1;
    fire  = 1'b0;
    res   = '0;
    if (cmd == CMD_PIXEL && frame_in < total) begin
      ring_px[frame_in % RING_D] = px;
      frame_in++;
      fire = frame_in > lag;
    end else if (frame_in == total && frame_out < total) begin
      fire = 1'b1;
    end
    if (!fire) return 1'b0;
    acc  = ring_px[frame_out % RING_D];
    if (out_row >= g && out_row + g < h && out_col >= g && out_col + g < w) begin
      up = ring_px[(frame_out - r * w) % RING_D];
      dn = ring_px[(frame_out + r * w) % RING_D];
      lf = ring_px[(frame_out - r) % RING_D];
      rt = ring_px[(frame_out + r) % RING_D];
      for (k = 0; k < 3; k++) begin
        sum = 10'(up[8*k +: 8]) + 10'(dn[8*k +: 8]) + 10'(lf[8*k +: 8]) + 10'(rt[8*k +: 8]);
        acc[8*k +: 8] = sum[9:2];
      end
    end
    res.px   = pix_t'(acc);
    res.last = (frame_out + 1 == total);
    frame_out++;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (frame_out == total) restart_frame();
    return 1'b1;
  endfunction

  function automatic pix_t rand_px();
    return pix_t'(24'($urandom()));
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    stim_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.val   = CFG_DATA_W'(val);
    row.cmd   = CMD_PIXEL;
    row.px    = '0;
    row.known = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endfunction

  // px and want pixels are written c,b,a from the top byte down
  function automatic void add_word(logic cmd, logic [23:0] px, bit known = 1'b0,
                                   blur_word_t want = '0);
    stim_row_t row;
    row.kind  = ROW_WORD;
    row.idx   = REG_RADIUS;
    row.val   = '0;
    row.cmd   = cmd;
    row.px    = px;
    row.known = known;
    row.want  = want;
    script.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  task automatic send_word(input logic cmd, input pix_t px, input bit known = 1'b0,
                           input blur_word_t want = '0);
    blur_word_t res;
    while (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.chan_a <= px.ch_a;
    in_ch.chan_b <= px.ch_b;
    in_ch.chan_c <= px.ch_c;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (cross_mean_step(cmd, px, res)) owed_px.push_back(known ? want : res);
    items_sent++;
  endtask

  // no word in flight and nothing owed, plus the pipeline depth
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (owed_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    set_reg(idx, CFG_DATA_W'(val));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned r, input int unsigned w, input int unsigned h);
    settle();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic random_geometry();
    int unsigned r, w, h, pick;
    pick = $urandom_range(99);
    r = ($urandom_range(99) < 70) ? $urandom_range(3, 1) : $urandom_range(8, 4);
    w = $urandom_range(2 * r + 6, 1);
    h = $urandom_range(2 * r + 6, 1);
    if (pick < 5) r = $urandom_range(15, 9);
    else if (pick < 8) r = 0;
    if ($urandom_range(99) < 4) w = 0;
    if ($urandom_range(99) < 4) h = 0;
    set_geometry(r, w, h);
    if ($urandom_range(99) < 5) write_reg(REG_SPARE, $urandom_range(2047, 0));
  endtask

  // Noisy frames get stray drains, dropped pixels in the flush, and sometimes stop early.
  task automatic run_frame(input bit noisy);
    int unsigned total, stop, sent;
    total = clamp_reg(wid_reg, DEF_MAX_WIDTH) * clamp_reg(hgt_reg, DEF_MAX_HEIGHT);
    stop  = (noisy && $urandom_range(99) < 6) ? $urandom_range(total - 1, 0) : total;
    sent  = 0;
    while (sent < stop) begin
      if (noisy && $urandom_range(99) < 4) begin
        send_word(CMD_DRAIN, rand_px());
      end else begin
        send_word(CMD_PIXEL, rand_px());
        sent++;
      end
    end
    if (stop < total) return;
    while (frame_in != 0)
      send_word((noisy && $urandom_range(99) < 10) ? CMD_PIXEL : CMD_DRAIN, rand_px());
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= calm || $urandom_range(99) >= 10;
      end
    end
  end

  always @(posedge clk) begin
    blur_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (owed_px.size() == 0) begin
        mismatches++;
        $error("output word %h %h %h with none owed", out_ch.out_c, out_ch.out_b,
               out_ch.out_a);
      end else begin
        want = owed_px.pop_front();
        check_field("out_a", want.px.ch_a, out_ch.out_a);
        check_field("out_b", want.px.ch_b, out_ch.out_b);
        check_field("out_c", want.px.ch_c, out_ch.out_c);
        check_field("frame_end", 8'(want.last), 8'(out_ch.frame_end));
        if (want.last) frames_seen++;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("cross_stencil_blur verification failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_RADIUS;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_PIXEL;
    in_ch.chan_a = '0;
    in_ch.chan_b = '0;
    in_ch.chan_c = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_word(CMD_DRAIN, 24'hFFFFFF);                       // nothing pending after reset
    add_reg(REG_RADIUS, 0);                                // clamps to 1
    add_reg(REG_WIDTH, 0);                                 // clamps to 1
    add_reg(REG_HEIGHT, 1);
    add_word(CMD_PIXEL, 24'hA500FF);
    add_word(CMD_DRAIN, 24'h000000, 1'b1, {24'hA500FF, 1'b1});
    add_word(CMD_DRAIN, 24'h5A5A5A);
    add_word(CMD_PIXEL, 24'h5AFF00);
    add_word(CMD_PIXEL, 24'h563412, 1'b1, {24'h5AFF00, 1'b1});  // dropped, flushes
    add_reg(REG_WIDTH, 3);
    add_reg(REG_HEIGHT, 3);
    add_word(CMD_PIXEL, 24'h017F80);
    add_word(CMD_PIXEL, 24'h7F8001);
    add_reg(REG_WIDTH, 2);                                 // restart mid-frame
    add_reg(REG_HEIGHT, 1);
    add_word(CMD_PIXEL, 24'h332211);
    add_reg(REG_SPARE, 2047);                              // no register, no restart
    add_word(CMD_DRAIN, 24'hFFFFFF);                       // frame still short
    add_word(CMD_PIXEL, 24'h665544);
    add_word(CMD_DRAIN, 24'h000000, 1'b1, {24'h332211, 1'b0});
    add_word(CMD_DRAIN, 24'h000000, 1'b1, {24'h665544, 1'b1});
    add_word(CMD_DRAIN, 24'h000000);
    add_reg(REG_RADIUS, 15);                               // clamps to 8
    add_word(CMD_PIXEL, 24'h000000);
    add_word(CMD_PIXEL, 24'hFFFFFF);
    add_word(CMD_DRAIN, 24'hFFFFFF, 1'b1, {24'h000000, 1'b0});
    add_word(CMD_DRAIN, 24'h000000, 1'b1, {24'hFFFFFF, 1'b1});

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle();
        write_reg(script[i].idx, 32'(script[i].val));
      end else begin
        send_word(script[i].cmd, script[i].px, script[i].known, script[i].want);
      end
    end

    // register extremes, one small frame each
    set_geometry(15, 4, 3);
    run_frame(1'b0);
    set_geometry(0, 1, 6);
    run_frame(1'b0);
    set_geometry(1, 0, 5);
    run_frame(1'b0);
    set_geometry(3, 7, 0);
    run_frame(1'b0);
    set_geometry(2, 9, 9);
    run_frame(1'b0);

    // receiver holds off over a whole frame, so the stalled output backs up to the input
    calm = 1'b1;
    set_geometry(2, 12, 12);
    hold_now = 1'b1;
    run_frame(1'b0);
    calm = 1'b0;

    phase = 0;
    while (items_sent < ITEM_BUDGET) begin
      calm = (phase >= 3 && phase < 10);
      random_geometry();
      run_frame(1'b1);
      phase++;
    end
    calm = 1'b0;
    settle();

    $display("%0d output words checked across %0d finished frames, %0d mismatches",
             words_seen, frames_seen, mismatches);
    $display("%0d words sent, %0d random frames; radius 0..15, sides 0..22, drains, drops, %s",
             items_sent, phase, "restarts, long output stall");
    if (mismatches == 0 && owed_px.size() == 0) begin
      $display("cross_stencil_blur verification clean");
    end else begin
      $display("cross_stencil_blur verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/csb_pkg.sv
sv/csb_if.sv
sv/csb_ram.sv
sv/csb_ctrl.sv
sv/csb_out.sv
sv/cross_stencil_blur.sv
bench/tb_cross_stencil_blur.sv
